// File: hdl/masp_pkg.sv
// ----------------------------------------------------------------------------
// masp_pkg
// Shared types and constants of the multi-axis step pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package masp_pkg;

    localparam int          AXES       = 4;
    localparam int unsigned FRAC_BITS  = 32;
    localparam int unsigned ACCEL_SHFT = 22;
    localparam logic [1:0]  SENSE_UP   = 2'b01;
    localparam logic [1:0]  SENSE_DOWN = 2'b10;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_LOAD   = 3'd1,
        ACT_COMMIT = 3'd2,
        ACT_STOP   = 3'd3,
        ACT_MANUAL = 3'd4,
        ACT_SETPOS = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_UP   = 2'd1,
        PH_CONST = 2'd2,
        PH_DOWN = 2'd3
    } phase_t;

    // One input beat
    typedef struct packed {
        logic [63:0] ramp_down_start;
        logic [63:0] ramp_up_end;
        logic [1:0]  ramp_sense;
        logic [1:0]  lead_axis;
        logic [3:0]  axis_mask;
        logic [3:0]  dir_bits;
        logic [31:0] target_pos;
        logic [31:0] accel_step;
        logic [30:0] start_rate;
        logic [30:0] const_rate;
        logic [1:0]  axis;
        logic [2:0]  action;
    } item_t;

    // One result beat
    typedef struct packed {
        logic [31:0] position;
        logic        tick_10ms;
        logic        accepted;
        logic        pending;
        logic        busy_res;
        logic [1:0]  phase;
        logic [3:0]  dir_out;
        logic [3:0]  step_out;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/masp_core.sv
// ----------------------------------------------------------------------------
// masp_core
// Holds all generator state and applies one registered item per cycle while item_valid is high.
// ----------------------------------------------------------------------------
`default_nettype none

module masp_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire masp_pkg::item_t   item,
    input  wire logic [7:0]        pulse_width_ticks,
    input  wire logic [15:0]       ticks_per_10ms,
    output masp_pkg::result_t      result
);
    import masp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [AXES-1:0] active_reg, active_next;
    logic [3:0]  dir_reg, dir_next;
    logic [1:0]  lead_reg, lead_next;
    logic [1:0]  sense_reg, sense_next;
    logic [63:0] pt0_reg, pt0_next, pt1_reg, pt1_next;
    logic [63:0] dist_reg [AXES], dist_next [AXES];
    logic [31:0] whole_reg [AXES], whole_next [AXES];
    logic [63:0] racc_reg [AXES], racc_next [AXES];
    logic [31:0] rate_reg [AXES], rate_next [AXES];
    logic [31:0] crate_reg [AXES], crate_next [AXES];
    logic [31:0] accel_reg [AXES], accel_next [AXES];
    logic [31:0] tgt_reg [AXES], tgt_next [AXES];
    logic [31:0] pos_reg [AXES], pos_next [AXES];
    logic [8:0]  cnt_reg [AXES], cnt_next [AXES];
    logic [AXES-1:0] pmask_reg, pmask_next;
    logic [30:0] s_crate_reg [AXES], s_crate_next [AXES];
    logic [30:0] s_srate_reg [AXES], s_srate_next [AXES];
    logic [31:0] s_acc_reg [AXES], s_acc_next [AXES];
    logic [31:0] s_tgt_reg [AXES], s_tgt_next [AXES];
    logic [3:0]  sm_dir_reg, sm_dir_next, sm_mask_reg, sm_mask_next;
    logic [1:0]  sm_lead_reg, sm_lead_next, sm_sense_reg, sm_sense_next;
    logic [63:0] sm_up_reg, sm_up_next, sm_down_reg, sm_down_next;
    logic        svalid_reg, svalid_next;
    logic [15:0] period_reg, period_next;
    result_t     result_next;

    // Apply one item to the state
    always_comb begin
        logic [63:0] lead_d;
        logic        up;
        logic [63:0] a;
        logic        acc_ok;
        logic        flag;
        logic [15:0] pc;
        logic [AXES-1:0] act_tmp;
        logic        in_range;
        logic        do_start;
        phase_next = phase_reg; active_next = active_reg; dir_next = dir_reg;
        lead_next = lead_reg; sense_next = sense_reg;
        pt0_next = pt0_reg; pt1_next = pt1_reg;
        pmask_next = pmask_reg;
        sm_dir_next = sm_dir_reg; sm_mask_next = sm_mask_reg;
        sm_lead_next = sm_lead_reg; sm_sense_next = sm_sense_reg;
        sm_up_next = sm_up_reg; sm_down_next = sm_down_reg;
        svalid_next = svalid_reg; period_next = period_reg;
        acc_ok = 1'b0; flag = 1'b0; do_start = 1'b0;
        lead_d = '0; up = 1'b0; a = '0; pc = '0; act_tmp = '0;
        in_range = ({30'd0, item.axis} < AXES);
        for (int k = 0; k < AXES; k++) begin
            dist_next[k] = dist_reg[k]; whole_next[k] = whole_reg[k];
            racc_next[k] = racc_reg[k]; rate_next[k] = rate_reg[k];
            crate_next[k] = crate_reg[k]; accel_next[k] = accel_reg[k];
            tgt_next[k] = tgt_reg[k]; pos_next[k] = pos_reg[k];
            cnt_next[k] = cnt_reg[k];
            s_crate_next[k] = s_crate_reg[k]; s_srate_next[k] = s_srate_reg[k];
            s_acc_next[k] = s_acc_reg[k]; s_tgt_next[k] = s_tgt_reg[k];
        end
        if (item_valid) begin
            case (item.action)
                ACT_TICK: begin
                    // release pulses
                    for (int k = 0; k < AXES; k++) begin
                        if (pmask_reg[k]) begin
                            cnt_next[k] = cnt_reg[k] - 9'd1;
                            if (cnt_next[k] == 9'd0) pmask_next[k] = 1'b0;
                        end
                    end
                    if (phase_reg != PH_IDLE) begin
                        // advance the active axes
                        for (int k = 0; k < AXES; k++) begin
                            if (active_reg[k]) begin
                                dist_next[k] = dist_reg[k] + {32'd0, rate_reg[k]};
                                if (dist_next[k][63:32] != whole_reg[k]) begin
                                    pos_next[k] = dir_reg[k] ? pos_reg[k] + 32'd1
                                                             : pos_reg[k] - 32'd1;
                                    if (pos_next[k] == tgt_reg[k])
                                        active_next[k] = 1'b0;
                                    whole_next[k] = dist_next[k][63:32];
                                    cnt_next[k] = {1'b0, pulse_width_ticks};
                                    pmask_next[k] = 1'b1;
                                end
                            end
                        end
                        for (int k = 0; k < AXES; k++)
                            if (lead_reg == k[1:0]) lead_d = dist_next[k];
                        // ramp machine
                        if (phase_reg == PH_UP && lead_d >= pt0_reg) begin
                            phase_next = PH_CONST;
                            for (int k = 0; k < AXES; k++) begin
                                rate_next[k] = crate_reg[k];
                                racc_next[k] = {crate_reg[k], 32'd0};
                            end
                        end else if (phase_reg == PH_CONST) begin
                            if (lead_d >= pt1_reg) phase_next = PH_DOWN;
                        end else begin
                            up = (phase_reg == PH_UP) ? ((sense_reg & SENSE_UP) != 2'b00)
                                                      : ((sense_reg & SENSE_DOWN) != 2'b00);
                            for (int k = 0; k < AXES; k++) begin
                                a = {10'd0, accel_reg[k], 22'd0};
                                if (up) racc_next[k] = racc_reg[k] + a;
                                else if (racc_reg[k] > a) racc_next[k] = racc_reg[k] - a;
                                rate_next[k] = racc_next[k][63:32];
                            end
                        end
                        if (active_next == '0) begin
                            phase_next = PH_IDLE;
                            do_start = svalid_reg;
                        end
                    end else begin
                        do_start = svalid_reg;
                    end
                    if (do_start) begin
                        act_tmp = sm_mask_reg[AXES-1:0];
                        active_next = act_tmp;
                        dir_next = sm_dir_reg; lead_next = sm_lead_reg;
                        sense_next = sm_sense_reg;
                        pt0_next = sm_up_reg; pt1_next = sm_down_reg;
                        svalid_next = 1'b0;
                        phase_next = PH_UP;
                        for (int k = 0; k < AXES; k++) begin
                            rate_next[k] = {1'b0, s_srate_reg[k]};
                            crate_next[k] = {1'b0, s_crate_reg[k]};
                            accel_next[k] = s_acc_reg[k];
                            tgt_next[k] = s_tgt_reg[k];
                            dist_next[k] = '0; whole_next[k] = '0;
                            racc_next[k] = {1'b0, s_srate_reg[k], 32'd0};
                        end
                    end
                    pc = period_reg + 16'd1;
                    if (pc == ticks_per_10ms) begin
                        period_next = '0; flag = 1'b1;
                    end else begin
                        period_next = pc;
                    end
                end
                ACT_LOAD: begin
                    if (!svalid_reg) begin
                        acc_ok = 1'b1;
                        for (int k = 0; k < AXES; k++) begin
                            if (item.axis == k[1:0]) begin
                                s_crate_next[k] = item.const_rate;
                                s_srate_next[k] = item.start_rate;
                                s_acc_next[k] = item.accel_step;
                                s_tgt_next[k] = item.target_pos;
                            end
                        end
                    end
                end
                ACT_COMMIT: begin
                    if (!svalid_reg) begin
                        acc_ok = 1'b1;
                        sm_dir_next = item.dir_bits; sm_mask_next = item.axis_mask;
                        sm_lead_next = item.lead_axis; sm_sense_next = item.ramp_sense;
                        sm_up_next = item.ramp_up_end; sm_down_next = item.ramp_down_start;
                        svalid_next = (item.axis_mask != 4'd0);
                    end
                end
                ACT_STOP: begin
                    phase_next = PH_IDLE; svalid_next = 1'b0; active_next = '0;
                end
                ACT_MANUAL: begin
                    dir_next = item.dir_bits;
                    for (int k = 0; k < AXES; k++) begin
                        if (item.axis_mask[k]) begin
                            pos_next[k] = item.dir_bits[k] ? pos_reg[k] + 32'd1
                                                           : pos_reg[k] - 32'd1;
                            cnt_next[k] = {1'b0, pulse_width_ticks} + 9'd1;
                            pmask_next[k] = 1'b1;
                        end
                    end
                end
                ACT_SETPOS: begin
                    for (int k = 0; k < AXES; k++)
                        if (item.axis == k[1:0]) pos_next[k] = item.target_pos;
                end
                default: begin
                end
            endcase
        end
        // form the result
        result_next.step_out = 4'(pmask_next);
        result_next.dir_out  = dir_next;
        result_next.phase    = phase_next;
        result_next.busy_res = (phase_next != PH_IDLE);
        result_next.pending  = svalid_next;
        result_next.accepted = acc_ok;
        result_next.tick_10ms = flag;
        result_next.position = '0;
        for (int k = 0; k < AXES; k++)
            if (in_range && item.axis == k[1:0]) result_next.position = pos_next[k];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; active_reg <= '0; dir_reg <= '0;
            lead_reg <= '0; sense_reg <= '0; pt0_reg <= '0; pt1_reg <= '0;
            pmask_reg <= '0; svalid_reg <= 1'b0; period_reg <= '0;
            sm_dir_reg <= '0; sm_mask_reg <= '0; sm_lead_reg <= '0;
            sm_sense_reg <= '0; sm_up_reg <= '0; sm_down_reg <= '0;
            for (int k = 0; k < AXES; k++) begin
                dist_reg[k] <= '0; whole_reg[k] <= '0; racc_reg[k] <= '0;
                rate_reg[k] <= '0; crate_reg[k] <= '0; accel_reg[k] <= '0;
                tgt_reg[k] <= '0; pos_reg[k] <= '0; cnt_reg[k] <= '0;
                s_crate_reg[k] <= '0; s_srate_reg[k] <= '0;
                s_acc_reg[k] <= '0; s_tgt_reg[k] <= '0;
            end
        end else begin
            phase_reg <= phase_next; active_reg <= active_next; dir_reg <= dir_next;
            lead_reg <= lead_next; sense_reg <= sense_next;
            pt0_reg <= pt0_next; pt1_reg <= pt1_next;
            pmask_reg <= pmask_next; svalid_reg <= svalid_next;
            period_reg <= period_next;
            sm_dir_reg <= sm_dir_next; sm_mask_reg <= sm_mask_next;
            sm_lead_reg <= sm_lead_next; sm_sense_reg <= sm_sense_next;
            sm_up_reg <= sm_up_next; sm_down_reg <= sm_down_next;
            for (int k = 0; k < AXES; k++) begin
                dist_reg[k] <= dist_next[k]; whole_reg[k] <= whole_next[k];
                racc_reg[k] <= racc_next[k]; rate_reg[k] <= rate_next[k];
                crate_reg[k] <= crate_next[k]; accel_reg[k] <= accel_next[k];
                tgt_reg[k] <= tgt_next[k]; pos_reg[k] <= pos_next[k];
                cnt_reg[k] <= cnt_next[k];
                s_crate_reg[k] <= s_crate_next[k]; s_srate_reg[k] <= s_srate_next[k];
                s_acc_reg[k] <= s_acc_next[k]; s_tgt_reg[k] <= s_tgt_next[k];
            end
        end
    end

    assign result = result_next;

endmodule

`default_nettype wire

// File: hdl/multi_axis_step_pulse_generator.sv
// ----------------------------------------------------------------------------
// multi_axis_step_pulse_generator
// Four-axis DDA step generator with trapezoidal ramps and a staged move slot.
// ----------------------------------------------------------------------------
// Usage: each input beat on s_axis carries one action (tick, load, commit,
// stop, manual step, set position). Each accepted beat yields exactly one
// result beat on m_axis with pin levels, phase, slot state and position.
// Path: an accepted beat is captured in the input register; when it advances,
// the core applies it and its result is captured into the output register
// together with the updated core state, and then shows on m_axis.
// Throughput: one beat per cycle while m_axis_tready is high, set by the
// single-pass update of all axis accumulators between input and output register.
// Reset (aresetn low, synchronous) clears all move state, positions, the
// staged slot and the period counter; registers return to width 2, period 500.
// When the receiver stalls, the output register holds its beat and the input
// register fills; s_axis_tready drops until the result moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_axis_step_pulse_generator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action, axis, const_rate, start_rate, accel_step, target_pos, dir_bits,
    // axis_mask, lead_axis, ramp_sense, ramp_up_end, ramp_down_start; 0-pad
    input  wire logic [271:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // step_out, dir_out, phase, busy_res, pending, accepted, tick_10ms,
    // position; 0-pad
    output logic [47:0]       m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_wdata
);
    import masp_pkg::*;

    item_t       in_reg;
    logic        in_valid_reg;
    result_t     res_reg;
    logic        res_valid_reg;
    result_t     core_res;
    logic [7:0]  pw_reg;
    logic [15:0] tp_reg;
    logic        advance;

    // core result moves to the output when the output is free or drained
    assign advance = in_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    masp_core u_core (
        .aclk(aclk), .aresetn(aresetn), .item_valid(advance), .item(in_reg),
        .pulse_width_ticks(pw_reg), .ticks_per_10ms(tp_reg), .result(core_res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) in_reg <= item_t'(s_axis_tdata[270:0]);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            res_valid_reg <= 1'b0;
        end
        if (advance) res_reg <= core_res;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg <= 8'd2; tp_reg <= 16'd500;
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) pw_reg <= cfg_wdata[7:0];
            else tp_reg <= cfg_wdata;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {2'd0, res_reg};

endmodule

`default_nettype wire
